// ===== src/tgtm_pkg.sv =====
package tgtm_pkg;

  // trigger table size and derived widths
  localparam int unsigned MAX_TRIGGERS = 8;
  localparam int unsigned IDX_W        = $clog2(MAX_TRIGGERS);
  localparam int unsigned CNT_W        = $clog2(MAX_TRIGGERS + 1);

  // field widths
  localparam int unsigned COORD_W = 10;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned TCNT_W  = 4;
  localparam int unsigned TABLE_W = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TABLE = 3'd4;

  // register reset values
  localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 10'd144;
  localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 10'd168;
  localparam logic [THR_W-1:0]   RST_TAP_THRESHOLD = 8'd18;

  // event codes
  localparam logic [1:0] EV_TOUCHDOWN = 2'd0;
  localparam logic [1:0] EV_LIFTOFF   = 2'd2;

  // zone codes
  localparam logic [2:0] AREA_NONE   = 3'd0;
  localparam logic [2:0] AREA_LEFT   = 3'd1;
  localparam logic [2:0] AREA_TOP    = 3'd2;
  localparam logic [2:0] AREA_RIGHT  = 3'd3;
  localparam logic [2:0] AREA_BOTTOM = 3'd4;
  localparam logic [2:0] AREA_CENTER = 3'd5;

  // gesture kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_TAP   = 2'd1;
  localparam logic [1:0] KIND_SWIPE = 2'd2;

  // actions
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_SILENCE   = 2'd1;
  localparam logic [1:0] ACT_SELECT    = 2'd2;
  localparam logic [1:0] ACT_UNMATCHED = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_ZONE,
    ST_DECIDE,
    ST_SRCH_INIT,
    ST_SRCH,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic calc_delta;
    logic calc_zone;
    logic srch_init;
    logic srch_step;
    logic set_retry;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic live;
    logic tap;
    logic ack;
    logic n_zero;
    logic hit;
    logic last;
    logic retry_avail;
  } sts_t;

endpackage

// ===== src/tgtm_ctrl.sv =====
module tgtm_ctrl
  import tgtm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd_o.calc_delta = 1'b1;
        state_d          = ST_ZONE;
      end
      ST_ZONE: begin
        cmd_o.calc_zone = 1'b1;
        state_d         = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts_i.live || (sts_i.tap && sts_i.ack)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_SRCH_INIT;
        end
      end
      ST_SRCH_INIT: begin
        cmd_o.srch_init = 1'b1;
        if (sts_i.n_zero) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.hit) begin
          state_d = ST_OUT;
        end else if (sts_i.last) begin
          if (sts_i.retry_avail) begin
            cmd_o.set_retry = 1'b1;
            state_d         = ST_SRCH_INIT;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result held until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/tgtm_dp.sv =====
module tgtm_dp
  import tgtm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]            event_type_i,
  input  logic [COORD_W-1:0]    touch_x_i,
  input  logic [COORD_W-1:0]    touch_y_i,
  input  logic                  ack_pending_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic [1:0]            action_o,
  output logic                  reveal_text_o,
  output logic [IDX_W-1:0]      selected_index_o,
  output logic [1:0]            gesture_kind_o,
  output logic [2:0]            from_zone_o,
  output logic [2:0]            to_zone_o
);

  // configuration registers
  logic [COORD_W-1:0] width_q, height_q;
  logic [THR_W-1:0]   thr_q;
  logic [TCNT_W-1:0]  tcnt_q;
  logic [TABLE_W-1:0] table_q;

  // touch state
  logic               tracking_q;
  logic [COORD_W-1:0] sx_q, sy_q;
  logic [IDX_W-1:0]   sel_q;

  // request registers
  logic [1:0]         ev_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic               ack_q, live_q;

  // classification registers
  logic [COORD_W-1:0] adx_q, ady_q, adx_d, ady_d;
  logic               dxneg_q, dyneg_q;
  logic [COORD_W-1:0] lb_q, rb_q, tb_q, bb_q;
  logic [1:0]         kind_q;
  logic [2:0]         fz_q, tz_q, df_q, dt_q;
  logic               retry_ok_q;

  // search registers
  logic               retry_q, found_q;
  logic [IDX_W-1:0]   idx_q, found_idx_q;
  logic [CNT_W-1:0]   cnt_q;

  // result registers
  logic [1:0]         action_q, gkind_q;
  logic               reveal_q;
  logic [IDX_W-1:0]   osel_q;
  logic [2:0]         ofz_q, otz_q;

  function automatic logic [2:0] zone_of(
    input logic [COORD_W-1:0] px,
    input logic [COORD_W-1:0] py,
    input logic [COORD_W-1:0] l,
    input logic [COORD_W-1:0] r,
    input logic [COORD_W-1:0] t,
    input logic [COORD_W-1:0] b
  );
    logic [2:0] z;
    if (py <= t) begin
      z = AREA_TOP;
    end else if (py >= b) begin
      z = AREA_BOTTOM;
    end else if (px <= l) begin
      z = AREA_LEFT;
    end else if (px >= r) begin
      z = AREA_RIGHT;
    end else begin
      z = AREA_CENTER;
    end
    return z;
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_SCREEN_WIDTH;
      height_q <= RST_SCREEN_HEIGHT;
      thr_q    <= RST_TAP_THRESHOLD;
      tcnt_q   <= '0;
      table_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SCREEN_WIDTH:  width_q  <= cfg_data_i[COORD_W-1:0];
        REG_SCREEN_HEIGHT: height_q <= cfg_data_i[COORD_W-1:0];
        REG_TAP_THRESHOLD: thr_q    <= cfg_data_i[THR_W-1:0];
        REG_TRIGGER_COUNT: tcnt_q   <= cfg_data_i[TCNT_W-1:0];
        REG_TRIGGER_TABLE: table_q  <= cfg_data_i[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // deltas
  logic [COORD_W:0] dx, dy;
  assign dx    = {1'b0, x_q} - {1'b0, sx_q};
  assign dy    = {1'b0, y_q} - {1'b0, sy_q};
  assign adx_d = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ady_d = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  // zones, tap test and direction pairs
  logic [2:0] fz_c, tz_raw, tz_c, df_c, dt_c;
  logic       tap_c, horiz;
  always_comb begin
    horiz  = (adx_q >= ady_q);
    fz_c   = zone_of(sx_q, sy_q, lb_q, rb_q, tb_q, bb_q);
    tz_raw = zone_of(x_q, y_q, lb_q, rb_q, tb_q, bb_q);
    tap_c  = ({{(COORD_W-THR_W){1'b0}}, thr_q} > adx_q) &&
             ({{(COORD_W-THR_W){1'b0}}, thr_q} > ady_q);
    if (horiz) begin
      df_c = dxneg_q ? AREA_RIGHT : AREA_LEFT;
      dt_c = dxneg_q ? AREA_LEFT : AREA_RIGHT;
    end else begin
      df_c = dyneg_q ? AREA_BOTTOM : AREA_TOP;
      dt_c = dyneg_q ? AREA_TOP : AREA_BOTTOM;
    end
    // same-zone swipe takes its end zone from the direction
    if (tap_c) begin
      tz_c = AREA_NONE;
    end else if (tz_raw == fz_c) begin
      tz_c = dt_c;
    end else begin
      tz_c = tz_raw;
    end
  end

  // search key and entry compare
  logic [TCNT_W-1:0] n_c;
  logic [2:0]        kfz, ktz;
  assign n_c = (tcnt_q > TCNT_W'(MAX_TRIGGERS)) ? TCNT_W'(MAX_TRIGGERS) : tcnt_q;
  assign kfz = retry_q ? df_q : fz_q;
  assign ktz = retry_q ? dt_q : tz_q;

  function automatic logic entry_hit(
    input logic [TABLE_W-1:0] tbl,
    input logic [IDX_W-1:0]   i,
    input logic [1:0]         k,
    input logic [2:0]         f,
    input logic [2:0]         t
  );
    logic [7:0] e;
    e = tbl[{i, 3'b000} +: 8];
    return (e[7:6] == k) && (e[5:3] == f) && (e[2:0] == t);
  endfunction

  logic              hit_c, sel_hit;
  logic [TCNT_W-1:0] start_c, first_c, next_c;
  assign hit_c   = entry_hit(table_q, idx_q, kind_q, kfz, ktz);
  assign sel_hit = ({1'b0, sel_q} < n_c) && entry_hit(table_q, sel_q, kind_q, kfz, ktz);
  assign start_c = sel_hit ? {1'b0, sel_q} : (n_c - 1'b1);
  assign first_c = (start_c + 1'b1 == n_c) ? '0 : start_c + 1'b1;
  assign next_c  = ({1'b0, idx_q} + 1'b1 == n_c) ? '0 : {1'b0, idx_q} + 1'b1;

  // request capture, classification and search
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      ev_q    <= event_type_i;
      x_q     <= touch_x_i;
      y_q     <= touch_y_i;
      ack_q   <= ack_pending_i;
      live_q  <= (event_type_i == EV_LIFTOFF) && tracking_q;
      retry_q <= 1'b0;
      found_q <= 1'b0;
    end
    if (cmd_i.calc_delta) begin
      adx_q   <= adx_d;
      ady_q   <= ady_d;
      dxneg_q <= dx[COORD_W];
      dyneg_q <= dy[COORD_W];
      lb_q    <= {2'b00, width_q[COORD_W-1:2]};
      rb_q    <= width_q - {2'b00, width_q[COORD_W-1:2]};
      tb_q    <= {2'b00, height_q[COORD_W-1:2]};
      bb_q    <= height_q - {2'b00, height_q[COORD_W-1:2]};
    end
    if (cmd_i.calc_zone) begin
      kind_q     <= tap_c ? KIND_TAP : KIND_SWIPE;
      fz_q       <= fz_c;
      tz_q       <= tz_c;
      df_q       <= df_c;
      dt_q       <= dt_c;
      retry_ok_q <= ((adx_q != '0) || (ady_q != '0)) &&
                    ((df_c != fz_c) || (dt_c != tz_c));
    end
    if (cmd_i.srch_init) begin
      idx_q <= first_c[IDX_W-1:0];
      cnt_q <= CNT_W'(n_c);
    end
    if (cmd_i.srch_step) begin
      if (hit_c) begin
        found_q     <= 1'b1;
        found_idx_q <= idx_q;
      end else begin
        idx_q <= next_c[IDX_W-1:0];
        cnt_q <= cnt_q - 1'b1;
      end
    end
    if (cmd_i.set_retry) begin
      retry_q <= 1'b1;
    end
  end

  // touch state update when the result is issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q <= 1'b0;
      sx_q       <= '0;
      sy_q       <= '0;
      sel_q      <= '0;
    end else if (cmd_i.load_out) begin
      if (ev_q == EV_TOUCHDOWN) begin
        tracking_q <= 1'b1;
        sx_q       <= x_q;
        sy_q       <= y_q;
      end else if (live_q) begin
        tracking_q <= 1'b0;
        if (found_q) begin
          sel_q <= found_idx_q;
        end
      end
    end
  end

  // result payload
  logic [1:0] act_c;
  logic       tap_r;
  assign tap_r = (kind_q == KIND_TAP);
  always_comb begin
    if (!live_q) begin
      act_c = ACT_NONE;
    end else if (tap_r && ack_q) begin
      act_c = ACT_SILENCE;
    end else if (found_q) begin
      act_c = ACT_SELECT;
    end else begin
      act_c = ACT_UNMATCHED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      action_q <= act_c;
      reveal_q <= live_q && ((tap_r && !ack_q) || (!tap_r && found_q));
      osel_q   <= (live_q && found_q) ? found_idx_q : sel_q;
      gkind_q  <= live_q ? kind_q : KIND_NONE;
      ofz_q    <= live_q ? fz_q : AREA_NONE;
      otz_q    <= (live_q && !tap_r) ? tz_q : AREA_NONE;
    end
  end

  assign sts_o.live        = live_q;
  assign sts_o.tap         = tap_r;
  assign sts_o.ack         = ack_q;
  assign sts_o.n_zero      = (n_c == '0);
  assign sts_o.hit         = hit_c;
  assign sts_o.last        = (cnt_q == CNT_W'(1));
  assign sts_o.retry_avail = !tap_r && retry_ok_q && !retry_q;

  assign action_o         = action_q;
  assign reveal_text_o    = reveal_q;
  assign selected_index_o = osel_q;
  assign gesture_kind_o   = gkind_q;
  assign from_zone_o      = ofz_q;
  assign to_zone_o        = otz_q;

endmodule

// ===== src/touch_gesture_trigger_matcher_core.sv =====
// channel   signals                                     direction
// ------    ------------------------------------------  ---------
// in        in_valid_i / in_stall_o, event_type_i,      request in
//           touch_x_i, touch_y_i, ack_pending_i
// out       out_valid_o / out_stall_i, action_o,        result out
//           reveal_text_o, selected_index_o,
//           gesture_kind_o, from_zone_o, to_zone_o
// cfg       cfg_we_i, cfg_index_i, cfg_data_i           write only
//
// one request at a time, taken only when idle; events that need no search
// skip it, while a tracked liftoff other than an acknowledged tap runs the
// one-entry-per-cycle round-robin search over the table, at most twice
// the result sits in an output register; the next request is taken while it
// waits, and that one is then held in its last cycle until the result is taken
// reset loads the configuration defaults and clears touch state and selection
module touch_gesture_trigger_matcher_core
  import tgtm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            event_type_i,
  input  logic [COORD_W-1:0]    touch_x_i,
  input  logic [COORD_W-1:0]    touch_y_i,
  input  logic                  ack_pending_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            action_o,
  output logic                  reveal_text_o,
  output logic [IDX_W-1:0]      selected_index_o,
  output logic [1:0]            gesture_kind_o,
  output logic [2:0]            from_zone_o,
  output logic [2:0]            to_zone_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tgtm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // classification, search and state
  tgtm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .event_type_i     (event_type_i),
    .touch_x_i        (touch_x_i),
    .touch_y_i        (touch_y_i),
    .ack_pending_i    (ack_pending_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_o         (action_o),
    .reveal_text_o    (reveal_text_o),
    .selected_index_o (selected_index_o),
    .gesture_kind_o   (gesture_kind_o),
    .from_zone_o      (from_zone_o),
    .to_zone_o        (to_zone_o)
  );

endmodule
